FILE: rtl/core/hcbd_pkg.sv
`timescale 1ns / 1ps

package hcbd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_OVF  = 2'd2;

  // Characters that steer the size line and the trailer section
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Bits that one hex digit adds to the size
  localparam int unsigned HEX_BITS = 4;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  // Per-line status of the chunk-size parser
  typedef struct packed {
    logic digits_open;
    logic seen_digit;
    logic overflow;
  } size_line_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [1:0] kind;
  } out_beat_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] ch);
    hex_digit_t d;
    d.is_hex = 1'b0;
    d.value  = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d.is_hex = 1'b1;
      d.value  = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      // 'a'..'f' and 'A'..'F' share their low three bits: 1..6 -> 10..15
      d.is_hex = 1'b1;
      d.value  = {1'b0, ch[2:0]} + 4'd9;
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/hcbd_in_if.sv
`timescale 1ns / 1ps

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: rtl/core/hcbd_out_if.sv
`timescale 1ns / 1ps

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] kind;

  modport source (output valid, output payload_byte, output kind, input ready);
  modport sink (input valid, input payload_byte, input kind, output ready);
endinterface

FILE: rtl/core/hcbd_size_acc.sv
`timescale 1ns / 1ps

// Chunk-size line digit accumulator: one byte per call, saturating.
module hcbd_size_acc #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic [7:0]             line_byte,
  input  logic [SIZE_BITS-1:0]   accum,
  input  hcbd_pkg::size_line_t   line,
  output logic [SIZE_BITS-1:0]   accum_next,
  output hcbd_pkg::size_line_t   line_next,
  output logic                   ovf_pulse
);

  hcbd_pkg::hex_digit_t hex;

  always_comb begin
    hex        = hcbd_pkg::hex_decode(line_byte);
    accum_next = accum;
    line_next  = line;
    ovf_pulse  = 1'b0;
    if (line.digits_open) begin
      if (hex.is_hex) begin
        line_next.seen_digit = 1'b1;
        // Any bit set in the top digit means one more shift would lose it
        if (|accum[SIZE_BITS-1 -: hcbd_pkg::HEX_BITS]) begin
          accum_next = '1;
          if (!line.overflow) begin
            line_next.overflow = 1'b1;
            ovf_pulse          = 1'b1;
          end
        end else begin
          accum_next = {accum[SIZE_BITS-hcbd_pkg::HEX_BITS-1:0], hex.value};
        end
      end else if (!line.seen_digit &&
                   (line_byte == hcbd_pkg::CH_SPACE || line_byte == hcbd_pkg::CH_TAB)) begin
        // leading blank: skip
      end else begin
        // first non-hex byte closes the number; extensions are ignored
        line_next.digits_open = 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/http_chunked_body_decoder.sv
`timescale 1ns / 1ps

// Channel  | Role  | Beat fields                      | Notes
// ---------+-------+----------------------------------+---------------------------------
// in_ch    | sink  | stream_byte[7:0]                 | raw chunked body, one byte a beat
// out_ch   | source| payload_byte[7:0], kind[1:0]     | data, end of body, size overflow
//
// One byte is accepted per cycle while the skid register is free; the parser state and
// any result update at the accepting edge, the result going into the skid register if
// the head is stalled, else into the output register, offered from the next cycle on.
// Results queue in a two-entry output buffer (output register plus skid register), so
// in_ch.ready drops only while both entries hold beats that out_ch has not taken.
// Reset (rst, synchronous, active high) returns the parser to reading a size line
// and empties the output buffer.
// Every byte, whether it produces a result or not, waits while the skid register is
// full; with out_ch ready on every cycle the input never stalls.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  hcbd_in_if.sink    in_ch,
  hcbd_out_if.source out_ch
);

  typedef enum logic [1:0] {
    PH_SIZE,   // reading a chunk-size line
    PH_DATA,   // passing payload bytes
    PH_DROP,   // discarding the two bytes after the data
    PH_TRAIL   // trailer section after a zero size
  } phase_t;

  // Parser state
  phase_t                    phase, phase_next;
  logic [SIZE_BITS-1:0]      chunk_remaining, chunk_remaining_next;
  logic [SIZE_BITS-1:0]      size_accum, size_accum_next;
  hcbd_pkg::size_line_t      line, line_next;
  logic [1:0]                crlf_progress, crlf_progress_next;

  // Output buffer: head register and skid register
  logic                      o_valid;
  hcbd_pkg::out_beat_t       o_beat;
  logic                      s_valid;
  hcbd_pkg::out_beat_t       s_beat;

  logic                      accept;
  logic                      pop;
  logic                      push;
  hcbd_pkg::out_beat_t       new_beat;

  logic [SIZE_BITS-1:0]      acc_after;
  hcbd_pkg::size_line_t      line_after;
  logic                      ovf_pulse;
  logic [SIZE_BITS-1:0]      rem_dec;

  localparam hcbd_pkg::size_line_t LINE_START = '{digits_open: 1'b1,
                                                  seen_digit:  1'b0,
                                                  overflow:    1'b0};

  // Accept whenever the skid register is free: the head can then absorb or pass on
  assign in_ch.ready = !s_valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = o_valid && out_ch.ready;

  assign out_ch.valid        = o_valid;
  assign out_ch.payload_byte = o_beat.payload_byte;
  assign out_ch.kind         = o_beat.kind;

  hcbd_size_acc #(
    .SIZE_BITS (SIZE_BITS)
  ) u_size_acc (
    .line_byte  (in_ch.stream_byte),
    .accum      (size_accum),
    .line       (line),
    .accum_next (acc_after),
    .line_next  (line_after),
    .ovf_pulse  (ovf_pulse)
  );

  // Count down, holding at zero
  assign rem_dec = chunk_remaining - {{(SIZE_BITS-1){1'b0}}, (chunk_remaining != '0)};

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    size_accum_next      = size_accum;
    line_next            = line;
    crlf_progress_next   = crlf_progress;
    push                 = 1'b0;
    new_beat             = '{payload_byte: 8'd0, kind: hcbd_pkg::KIND_DATA};

    unique case (phase)
      PH_DATA: begin
        // Pass the byte; after the last one, drop the trailing pair
        chunk_remaining_next  = rem_dec;
        push                  = 1'b1;
        new_beat.payload_byte = in_ch.stream_byte;
        if (rem_dec == '0) begin
          phase_next         = PH_DROP;
          crlf_progress_next = 2'd0;
        end
      end

      PH_DROP: begin
        // Two bytes go by unchecked, then a fresh size line starts
        if (crlf_progress != 2'd0) begin
          phase_next         = PH_SIZE;
          size_accum_next    = '0;
          line_next          = LINE_START;
          crlf_progress_next = 2'd0;
        end else begin
          crlf_progress_next = crlf_progress + 2'd1;
        end
      end

      PH_TRAIL: begin
        // Look for CRLF CRLF; progress 2 means a line just ended
        if (in_ch.stream_byte == hcbd_pkg::CH_CR) begin
          crlf_progress_next = (crlf_progress == 2'd2) ? 2'd3 : 2'd1;
        end else if (in_ch.stream_byte == hcbd_pkg::CH_LF) begin
          if (crlf_progress == 2'd3) begin
            phase_next         = PH_SIZE;
            size_accum_next    = '0;
            line_next          = LINE_START;
            crlf_progress_next = 2'd0;
            push               = 1'b1;
            new_beat.kind      = hcbd_pkg::KIND_END;
          end else begin
            crlf_progress_next = (crlf_progress == 2'd1) ? 2'd2 : 2'd0;
          end
        end else begin
          crlf_progress_next = 2'd0;
        end
      end

      PH_SIZE: begin
        size_accum_next = acc_after;
        line_next       = line_after;
        if (ovf_pulse) begin
          push          = 1'b1;
          new_beat.kind = hcbd_pkg::KIND_OVF;
        end
        if (in_ch.stream_byte == hcbd_pkg::CH_CR) begin
          crlf_progress_next = 2'd1;
        end else if (in_ch.stream_byte == hcbd_pkg::CH_LF && crlf_progress == 2'd1) begin
          // Line ends: a zero (or missing) size opens the trailer section
          size_accum_next = '0;
          line_next       = LINE_START;
          if (acc_after == '0) begin
            phase_next         = PH_TRAIL;
            crlf_progress_next = 2'd2;
          end else begin
            phase_next           = PH_DATA;
            chunk_remaining_next = acc_after;
            crlf_progress_next   = 2'd0;
          end
        end else begin
          crlf_progress_next = 2'd0;
        end
      end

      default: begin
        phase_next = PH_SIZE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      size_accum      <= '0;
      line            <= LINE_START;
      crlf_progress   <= 2'd0;
      o_valid         <= 1'b0;
      s_valid         <= 1'b0;
    end else begin
      // Advance the parser only on an accepted beat
      if (accept) begin
        phase           <= phase_next;
        chunk_remaining <= chunk_remaining_next;
        size_accum      <= size_accum_next;
        line            <= line_next;
        crlf_progress   <= crlf_progress_next;
      end

      // Output buffer: the skid only fills while the head is stalled
      if (s_valid) begin
        if (pop) begin
          o_beat  <= s_beat;
          s_valid <= 1'b0;
        end
      end else if (accept && push) begin
        if (!o_valid || pop) begin
          o_beat  <= new_beat;
          o_valid <= 1'b1;
        end else begin
          s_beat  <= new_beat;
          s_valid <= 1'b1;
        end
      end else if (pop) begin
        o_valid <= 1'b0;
      end
    end
  end

  // A skid beat always sits behind a head beat
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid register holds a beat while the head is empty");

  // A stalled head with a skid beat keeps both until the head is taken
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !out_ch.ready) |=> (s_valid && o_valid))
    else $error("buffered beat lost while output was stalled");

  // Data phase is only entered with a nonzero count
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (chunk_remaining != '0))
    else $error("data phase with no bytes remaining");

  // Trailer section never carries a pending size
  a_trail_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TRAIL) |-> (size_accum == '0))
    else $error("size accumulator not cleared in trailer section");

  // Only data beats carry a payload byte
  a_ctrl_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_beat.kind != hcbd_pkg::KIND_DATA) |-> (o_beat.payload_byte == 8'd0))
    else $error("control beat with nonzero payload byte");

endmodule
